// ----- rtl/core/tor_pkg.sv -----
// ----------------------------------------------------------------------------
// tor_pkg
// Shared types and constants for the twelve-opcode core.
// ----------------------------------------------------------------------------
package tor_pkg;

  localparam int MEM_WORDS = 2048;
  localparam int MEM_AW    = 11;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_EXEC  = 2'd1,
    K_READM = 2'd2,
    K_READR = 2'd3
  } op_kind_t;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MULI = 4'd2;
  localparam logic [3:0] OP_ADDI = 4'd3;
  localparam logic [3:0] OP_BNE  = 4'd4;
  localparam logic [3:0] OP_ANDI = 4'd5;
  localparam logic [3:0] OP_ORI  = 4'd6;
  localparam logic [3:0] OP_J    = 4'd7;
  localparam logic [3:0] OP_SLL  = 4'd8;
  localparam logic [3:0] OP_SRL  = 4'd9;
  localparam logic [3:0] OP_LW   = 4'd10;
  localparam logic [3:0] OP_SW   = 4'd11;

  typedef struct packed {
    op_kind_t          kind;
    logic [MEM_AW-1:0] loc;
    logic [31:0]       word;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } fe_head_t;

  // laid out msb first so the packed value is the result tdata
  typedef struct packed {
    logic              program_end;
    logic              branch_taken;
    logic              mem_write;
    logic [31:0]       dest_value;
    logic [4:0]        dest_index;
    logic              reg_write;
    logic [3:0]        executed_opcode;
    logic [MEM_AW-1:0] next_pc;
    logic [31:0]       read_value;
  } rsp_t;

endpackage

// ----- rtl/core/tor_front.sv -----
// ----------------------------------------------------------------------------
// tor_front
// Accepts items, tags their kind and queues them for the execution side.
// ----------------------------------------------------------------------------
module tor_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              clearing,
  input  logic              pop,
  output tor_pkg::fe_head_t head
);
  import tor_pkg::*;

  q_item_t    fifo_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;
  q_item_t    item;

  assign in_tready = (cnt_r != 2'd2) && !clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    item.kind = op_kind_t'(in_tuser);
    item.loc  = in_tdata[10:0];
    item.word = in_tdata[42:11];
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = fifo_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && head.valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop && head.valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop && head.valid) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= item;
  end

endmodule

// ----- rtl/core/tor_back.sv -----
// ----------------------------------------------------------------------------
// tor_back
// Sequencer that runs queued items against memory and register file.
// ----------------------------------------------------------------------------
module tor_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tor_pkg::fe_head_t head,
  output logic              pop,
  output logic              clearing,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [87:0]       out_tdata
);
  import tor_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RDM, S_RDR, S_FETCH, S_EXEC, S_WB, S_RESP
  } state_t;

  state_t            state_r;
  logic [MEM_AW-1:0] clr_r, pc_r, npc_r;
  logic [31:0]       ins_r, res_r;
  logic              wreg_r, br_r, mw_r, lw_r;
  rsp_t              rsp_r;
  logic              out_valid_r;
  logic [87:0]       out_data_r;

  logic [31:0]       mem [MEM_WORDS];
  logic [31:0]       mem_q;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [31:0]       mem_wd;

  logic [31:0]       rf [32];
  logic [31:0]       rf_vld_r;
  logic [31:0]       rfa_q, rfb_q;
  logic              rfa_v, rfb_v;
  logic              rf_we;
  logic [4:0]        rf_wa, rf_ra_a, rf_ra_b;
  logic [31:0]       rf_wd, rfa, rfb;

  logic [3:0]        opc, f_opc;
  logic [4:0]        r1, r2, r3;
  logic [31:0]       imm_x, dsum, prod;
  logic [MEM_AW-1:0] daddr;

  logic [31:0]       ex_res;
  logic [MEM_AW-1:0] ex_npc;
  logic              ex_wreg, ex_br, ex_mw, ex_lw;

  assign clearing   = (state_r == S_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign opc   = ins_r[31:28];
  assign r1    = ins_r[27:23];
  assign r2    = ins_r[22:18];
  assign r3    = ins_r[17:13];
  assign imm_x = {{14{ins_r[17]}}, ins_r[17:0]};
  assign f_opc = mem_q[31:28];
  assign rfa   = rfa_v ? rfa_q : 32'd0;
  assign rfb   = rfb_v ? rfb_q : 32'd0;
  assign dsum  = rfb + imm_x;
  assign daddr = dsum[MEM_AW-1:0];
  assign prod  = rfb * imm_x;

  always_comb begin
    pop     = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = clr_r;
    mem_wd  = 32'd0;
    mem_ra  = pc_r;
    rf_we   = 1'b0;
    rf_wa   = r1;
    rf_wd   = lw_r ? mem_q : res_r;
    rf_ra_a = r1;
    rf_ra_b = r2;
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        pop     = head.valid;
        rf_ra_b = head.item.loc[4:0];
        if (head.item.kind != K_EXEC) mem_ra = head.item.loc;
        if (head.item.kind == K_WRITE) begin
          mem_we = head.valid;
          mem_wa = head.item.loc;
          mem_wd = head.item.word;
        end
      end
      S_FETCH: begin
        // operand a is r3 for register-register ops, else r1
        rf_ra_a = (f_opc == OP_ADD || f_opc == OP_SUB) ? mem_q[17:13] : mem_q[27:23];
        rf_ra_b = mem_q[22:18];
      end
      S_EXEC: begin
        mem_ra = daddr;
        if (opc == OP_SW) begin
          mem_we = 1'b1;
          mem_wa = daddr;
          mem_wd = rfa;
        end
      end
      S_WB: rf_we = wreg_r && (r1 != 5'd0);
      default: ;
    endcase
  end

  // execute stage decode
  always_comb begin
    ex_res  = 32'd0;
    ex_wreg = 1'b0;
    ex_br   = 1'b0;
    ex_mw   = 1'b0;
    ex_lw   = 1'b0;
    ex_npc  = pc_r + 1'b1;
    case (opc)
      OP_ADD:  begin ex_res = rfb + rfa;   ex_wreg = 1'b1; end
      OP_SUB:  begin ex_res = rfb - rfa;   ex_wreg = 1'b1; end
      OP_MULI: begin ex_res = prod;        ex_wreg = 1'b1; end
      OP_ADDI: begin ex_res = dsum;        ex_wreg = 1'b1; end
      OP_ANDI: begin ex_res = rfb & imm_x; ex_wreg = 1'b1; end
      OP_ORI:  begin ex_res = rfb | imm_x; ex_wreg = 1'b1; end
      OP_BNE: begin
        if (rfa != rfb) begin
          ex_npc = pc_r + 1'b1 + imm_x[MEM_AW-1:0];
          ex_br  = 1'b1;
        end
      end
      OP_J: begin
        ex_npc = ins_r[MEM_AW-1:0];
        ex_br  = 1'b1;
      end
      OP_SLL: begin
        ex_res  = (ins_r[12:5] == 8'd0) ? (rfb << ins_r[4:0]) : 32'd0;
        ex_wreg = 1'b1;
      end
      OP_SRL: begin
        ex_res  = (ins_r[12:5] == 8'd0) ? (rfb >> ins_r[4:0]) : 32'd0;
        ex_wreg = 1'b1;
      end
      OP_LW: begin
        ex_lw   = 1'b1;
        ex_wreg = 1'b1;
      end
      OP_SW: ex_mw = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    rfa_q <= rf[rf_ra_a];
    rfb_q <= rf[rf_ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= 32'd0;
      rfa_v    <= 1'b0;
      rfb_v    <= 1'b0;
    end else begin
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      rfa_v <= rf_vld_r[rf_ra_a];
      rfb_v <= rf_vld_r[rf_ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_RESP) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            rsp_r <= rsp_t'({45'd0, pc_r, 32'd0});
            unique case (head.item.kind)
              K_WRITE: state_r <= S_RESP;
              K_READM: state_r <= S_RDM;
              K_READR: state_r <= S_RDR;
              K_EXEC:  state_r <= S_FETCH;
            endcase
          end
        end
        S_RDM: begin
          rsp_r.read_value <= mem_q;
          state_r          <= S_RESP;
        end
        S_RDR: begin
          rsp_r.read_value <= rfb;
          state_r          <= S_RESP;
        end
        S_FETCH: begin
          ins_r <= mem_q;
          if (mem_q == 32'd0) begin
            rsp_r.program_end <= 1'b1;
            state_r           <= S_RESP;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_r   <= ex_res;
          wreg_r  <= ex_wreg;
          br_r    <= ex_br;
          mw_r    <= ex_mw;
          lw_r    <= ex_lw;
          npc_r   <= ex_npc;
          state_r <= S_WB;
        end
        S_WB: begin
          pc_r                  <= npc_r;
          rsp_r.next_pc         <= npc_r;
          rsp_r.executed_opcode <= opc;
          rsp_r.reg_write       <= rf_we;
          rsp_r.dest_index      <= rf_we ? r1 : 5'd0;
          rsp_r.dest_value      <= rf_we ? rf_wd : 32'd0;
          rsp_r.mem_write       <= mw_r;
          rsp_r.branch_taken    <= br_r;
          state_r               <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rsp_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/twelve_op_risc_core.sv -----
// ----------------------------------------------------------------------------
// twelve_op_risc_core
// Word-addressed twelve-opcode processor with shared program/data memory.
// ----------------------------------------------------------------------------
// After reset the core zeroes all 2048 memory words and takes no item
// until that pass ends. Items then go through a two-entry queue to a
// sequencer that owns the memory (one write and one read port) and the
// two-read register file: a memory or register read goes through a
// registered read, an executed instruction through fetch, operand read,
// execute with memory access, writeback and result.
module twelve_op_risc_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // location[10:0], load_word[42:11], zero fill
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[31:0], next_pc[42:32], executed_opcode[46:43], reg_write[47],
  // dest_index[52:48], dest_value[84:53], mem_write[85], branch_taken[86],
  // program_end[87]
  output logic [87:0] out_tdata
);
  import tor_pkg::*;

  fe_head_t head;
  logic     pop, clearing;

  tor_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .pop       (pop),
    .head      (head)
  );

  tor_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/core/tor_checker.sv -----
// ----------------------------------------------------------------------------
// tor_checker
// Port-level checks on the result stream of the core.
// ----------------------------------------------------------------------------
module tor_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  import tor_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[87] |-> out_tdata[46:43] == 4'd0 && !out_tdata[47]
      && !out_tdata[85] && !out_tdata[86])
    else $error("program end with side effects");

  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[47] |-> out_tdata[84:48] == 37'd0)
    else $error("destination fields without register write");

  a_sw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[85] |-> out_tdata[46:43] == OP_SW)
    else $error("memory write from non-store");

endmodule

bind twelve_op_risc_core tor_checker u_tor_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
